// ===== hdl/wbk_pkg.sv =====
package wbk_pkg;

   // field and datapath widths
   localparam int unsigned FieldW   = 16;
   localparam int unsigned SumW     = FieldW + 2;           // four-term wheel sums
   localparam int unsigned CoefW    = 24;
   localparam int unsigned ProdW    = SumW + CoefW + 1;     // signed x unsigned product
   localparam int unsigned BaseW    = 3;
   localparam int unsigned MaxRpmW  = 15;
   localparam int unsigned InvCoefW = 20;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 24;
   localparam int unsigned NumProd  = 3;

   // base types
   localparam logic [BaseW-1:0] BaseDiff = 3'd0;
   localparam logic [BaseW-1:0] BaseSkid = 3'd1;
   localparam logic [BaseW-1:0] BaseAck  = 3'd2;
   localparam logic [BaseW-1:0] BaseAck1 = 3'd3;
   localparam logic [BaseW-1:0] BaseMec  = 3'd4;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegBaseType      = 3'd0;
   localparam logic [CsrIdxW-1:0] RegMaxRpm        = 3'd1;
   localparam logic [CsrIdxW-1:0] RegRpmPerSpeed   = 3'd2;
   localparam logic [CsrIdxW-1:0] RegRpmPerTurn    = 3'd3;
   localparam logic [CsrIdxW-1:0] RegSpeedPerRpm   = 3'd4;
   localparam logic [CsrIdxW-1:0] RegTurnPerRpm    = 3'd5;

   // register reset values
   localparam logic [BaseW-1:0]    RstBaseType    = BaseMec;
   localparam logic [MaxRpmW-1:0]  RstMaxRpm      = 15'd330;
   localparam logic [InvCoefW-1:0] RstRpmPerSpeed = 20'd12524;
   localparam logic [InvCoefW-1:0] RstRpmPerTurn  = 20'd3000;
   localparam logic [CoefW-1:0]    RstSpeedPerRpm = 24'd342949;
   localparam logic [CoefW-1:0]    RstTurnPerRpm  = 24'd1400000;

   // control that travels alongside the products
   typedef struct packed {
      logic       forward;
      logic [1:0] wheel_shift;
   } prod_ctrl_type;

endpackage

// ===== hdl/wbk_prod_stage.sv =====
module wbk_prod_stage (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  wbk_pkg::prod_ctrl_type               in_ctrl,
   input  logic signed [wbk_pkg::SumW-1:0]      op_a [wbk_pkg::NumProd],
   input  logic        [wbk_pkg::CoefW-1:0]     op_b [wbk_pkg::NumProd],
   output logic                                 out_valid,
   output wbk_pkg::prod_ctrl_type               out_ctrl,
   output logic signed [wbk_pkg::ProdW-1:0]     prod [wbk_pkg::NumProd]
);
   import wbk_pkg::*;

   logic                      valid_ff;
   prod_ctrl_type             ctrl_ff;
   logic signed [ProdW-1:0]   prod_in [NumProd];
   logic signed [ProdW-1:0]   prod_ff [NumProd];

   // signed operand times unsigned coefficient, zero-extended to keep it positive
   always_comb begin
      for (int i = 0; i < NumProd; i++) begin
         prod_in[i] = ProdW'(op_a[i]) * ProdW'($signed({1'b0, op_b[i]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= in_ctrl;
      for (int i = 0; i < NumProd; i++) begin
         prod_ff[i] <= prod_in[i];
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign prod      = prod_ff;

endmodule

// ===== hdl/wheeled_base_kinematics.sv =====
// Channel   Ports                                         Direction  Transfer when
// request   start, busy, req_opcode, req_cmd_*, req_wheel_* in      start && !busy
// response  rsp_valid, rsp_drive_*, rsp_est_*              out       rsp_valid (one cycle)
// config    csr_valid, csr_ready, csr_index, csr_data      in        csr_valid && csr_ready
//
// One request per clock; busy is tied low and csr_ready high.
// Registered stages: input register, product register (three 18x25
// multipliers shared between the inverse and forward paths), result register.
// Synchronous active-high reset clears the valid pipeline and loads the
// register defaults. The receiver cannot stall; each result shows for one cycle.
module wheeled_base_kinematics (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic signed [wbk_pkg::FieldW-1:0]   req_cmd_forward,
   input  logic signed [wbk_pkg::FieldW-1:0]   req_cmd_sideways,
   input  logic signed [wbk_pkg::FieldW-1:0]   req_cmd_turn,
   input  logic signed [wbk_pkg::FieldW-1:0]   req_wheel_fl_rpm,
   input  logic signed [wbk_pkg::FieldW-1:0]   req_wheel_fr_rpm,
   input  logic signed [wbk_pkg::FieldW-1:0]   req_wheel_rl_rpm,
   input  logic signed [wbk_pkg::FieldW-1:0]   req_wheel_rr_rpm,
   output logic                                rsp_valid,
   output logic signed [wbk_pkg::FieldW-1:0]   rsp_drive_fl_rpm,
   output logic signed [wbk_pkg::FieldW-1:0]   rsp_drive_fr_rpm,
   output logic signed [wbk_pkg::FieldW-1:0]   rsp_drive_rl_rpm,
   output logic signed [wbk_pkg::FieldW-1:0]   rsp_drive_rr_rpm,
   output logic signed [wbk_pkg::FieldW-1:0]   rsp_est_forward,
   output logic signed [wbk_pkg::FieldW-1:0]   rsp_est_sideways,
   output logic signed [wbk_pkg::FieldW-1:0]   rsp_est_turn,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wbk_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [wbk_pkg::CsrDataW-1:0]        csr_data
);
   import wbk_pkg::*;

   // accumulator wide enough for three products plus sign growth
   localparam int unsigned AccW  = ProdW + 2;
   localparam int unsigned ShW   = 5;
   localparam logic [ShW-1:0] FracBits = 5'd16;

   // configuration registers
   logic [BaseW-1:0]    base_type_ff;
   logic [MaxRpmW-1:0]  max_rpm_ff;
   logic [InvCoefW-1:0] rpm_per_speed_ff;
   logic [InvCoefW-1:0] rpm_per_turn_ff;
   logic [CoefW-1:0]    speed_per_rpm_ff;
   logic [CoefW-1:0]    turn_per_rpm_ff;

   // input register
   logic                      a_valid_ff;
   logic                      a_opcode_ff;
   logic signed [FieldW-1:0]  a_fwd_ff, a_side_ff, a_turn_ff;
   logic signed [FieldW-1:0]  a_fl_ff, a_fr_ff, a_rl_ff, a_rr_ff;

   // operand selection
   logic signed [SumW-1:0]    op_a [NumProd];
   logic        [CoefW-1:0]   op_b [NumProd];
   prod_ctrl_type             a_ctrl;
   logic signed [SumW-1:0]    fl_x, fr_x, rl_x, rr_x;
   logic signed [SumW-1:0]    sum_x, sum_y, sum_w;
   logic signed [SumW-1:0]    side_x, turn_x, fwd_x;
   logic                      is_mec, is_ack;

   // product stage outputs
   logic                      b_valid;
   prod_ctrl_type             b_ctrl;
   logic signed [ProdW-1:0]   prod [NumProd];

   // combine, scale and clamp
   logic signed [AccW-1:0]    px, py, pr;
   logic signed [AccW-1:0]    q_fl, q_fr, q_rl, q_rr, q_ef, q_es, q_et;
   logic signed [AccW-1:0]    lim;
   logic [ShW-1:0]            fwd_shift;
   logic signed [FieldW-1:0]  drv_fl_in, drv_fr_in, drv_rl_in, drv_rr_in;
   logic signed [FieldW-1:0]  est_f_in, est_s_in, est_t_in;

   // result register
   logic                      rsp_valid_ff;
   logic signed [FieldW-1:0]  drv_fl_ff, drv_fr_ff, drv_rl_ff, drv_rr_ff;
   logic signed [FieldW-1:0]  est_f_ff, est_s_ff, est_t_ff;

   // divide by 2^n, truncating toward zero
   function automatic logic signed [AccW-1:0] shr_trunc(
      input logic signed [AccW-1:0] v,
      input logic [ShW-1:0]         n
   );
      logic signed [AccW-1:0] bias;
      bias = v[AccW-1] ? ((AccW'(1) << n) - AccW'(1)) : '0;
      return (v + bias) >>> n;
   endfunction

   function automatic logic signed [FieldW-1:0] sat16(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] hi, lo;
      hi = AccW'(32767);
      lo = -AccW'(32768);
      if (v > hi) begin
         return 16'sh7fff;
      end else if (v < lo) begin
         return 16'sh8000;
      end
      return v[FieldW-1:0];
   endfunction

   function automatic logic signed [FieldW-1:0] clamp_lim(
      input logic signed [AccW-1:0] v,
      input logic signed [AccW-1:0] l
   );
      if (v > l) begin
         return l[FieldW-1:0];
      end else if (v < -l) begin
         return FieldW'(-l);
      end
      return v[FieldW-1:0];
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration writes; unknown indexes drop the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         base_type_ff     <= RstBaseType;
         max_rpm_ff       <= RstMaxRpm;
         rpm_per_speed_ff <= RstRpmPerSpeed;
         rpm_per_turn_ff  <= RstRpmPerTurn;
         speed_per_rpm_ff <= RstSpeedPerRpm;
         turn_per_rpm_ff  <= RstTurnPerRpm;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            RegBaseType:    base_type_ff     <= csr_data[BaseW-1:0];
            RegMaxRpm:      max_rpm_ff       <= csr_data[MaxRpmW-1:0];
            RegRpmPerSpeed: rpm_per_speed_ff <= csr_data[InvCoefW-1:0];
            RegRpmPerTurn:  rpm_per_turn_ff  <= csr_data[InvCoefW-1:0];
            RegSpeedPerRpm: speed_per_rpm_ff <= csr_data[CoefW-1:0];
            RegTurnPerRpm:  turn_per_rpm_ff  <= csr_data[CoefW-1:0];
            default: ;
         endcase
      end
   end

   // capture a request on every accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         a_opcode_ff <= req_opcode;
         a_fwd_ff    <= req_cmd_forward;
         a_side_ff   <= req_cmd_sideways;
         a_turn_ff   <= req_cmd_turn;
         a_fl_ff     <= req_wheel_fl_rpm;
         a_fr_ff     <= req_wheel_fr_rpm;
         a_rl_ff     <= req_wheel_rl_rpm;
         a_rr_ff     <= req_wheel_rr_rpm;
      end
   end

   // pick multiplier operands: inverse scales the commands, forward the wheel sums
   always_comb begin
      is_mec = (base_type_ff == BaseMec);
      is_ack = (base_type_ff == BaseAck) || (base_type_ff == BaseAck1);

      fl_x  = SumW'(a_fl_ff);
      fr_x  = SumW'(a_fr_ff);
      rl_x  = SumW'(a_rl_ff);
      rr_x  = SumW'(a_rr_ff);
      sum_x = fl_x + fr_x + rl_x + rr_x;
      sum_y = fr_x + rl_x - fl_x - rr_x;
      sum_w = fr_x + rr_x - fl_x - rl_x;

      fwd_x  = SumW'(a_fwd_ff);
      side_x = is_mec ? SumW'(a_side_ff) : '0;
      turn_x = is_ack ? '0 : SumW'(a_turn_ff);

      case (base_type_ff)
         BaseAck1:         a_ctrl.wheel_shift = 2'd0;
         BaseSkid, BaseMec: a_ctrl.wheel_shift = 2'd2;
         default:          a_ctrl.wheel_shift = 2'd1;
      endcase
      a_ctrl.forward = a_opcode_ff;

      if (a_opcode_ff) begin
         op_a[0] = sum_x;
         op_a[1] = is_mec ? sum_y : '0;
         op_a[2] = sum_w;
         op_b[0] = speed_per_rpm_ff;
         op_b[1] = speed_per_rpm_ff;
         op_b[2] = turn_per_rpm_ff;
      end else begin
         op_a[0] = fwd_x;
         op_a[1] = side_x;
         op_a[2] = turn_x;
         op_b[0] = CoefW'(rpm_per_speed_ff);
         op_b[1] = CoefW'(rpm_per_speed_ff);
         op_b[2] = CoefW'(rpm_per_turn_ff);
      end
   end

   wbk_prod_stage u_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .in_ctrl   (a_ctrl),
      .op_a      (op_a),
      .op_b      (op_b),
      .out_valid (b_valid),
      .out_ctrl  (b_ctrl),
      .prod      (prod)
   );

   // form wheel sums or body estimates, shift out the Q16 fraction, then limit
   always_comb begin
      px  = AccW'(prod[0]);
      py  = AccW'(prod[1]);
      pr  = AccW'(prod[2]);
      lim = $signed(AccW'(max_rpm_ff));
      fwd_shift = FracBits + ShW'(b_ctrl.wheel_shift);

      q_fl = shr_trunc(px - py - pr, FracBits);
      q_fr = shr_trunc(px + py + pr, FracBits);
      q_rl = shr_trunc(px + py - pr, FracBits);
      q_rr = shr_trunc(px - py + pr, FracBits);
      q_ef = shr_trunc(px, fwd_shift);
      q_es = shr_trunc(py, fwd_shift);
      q_et = shr_trunc(pr, fwd_shift);

      if (b_ctrl.forward) begin
         drv_fl_in = '0;
         drv_fr_in = '0;
         drv_rl_in = '0;
         drv_rr_in = '0;
         est_f_in  = sat16(q_ef);
         est_s_in  = sat16(q_es);
         est_t_in  = sat16(q_et);
      end else begin
         drv_fl_in = clamp_lim(q_fl, lim);
         drv_fr_in = clamp_lim(q_fr, lim);
         drv_rl_in = clamp_lim(q_rl, lim);
         drv_rr_in = clamp_lim(q_rr, lim);
         est_f_in  = '0;
         est_s_in  = '0;
         est_t_in  = '0;
      end
   end

   // result register: strobe for one cycle per request
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid) begin
         drv_fl_ff <= drv_fl_in;
         drv_fr_ff <= drv_fr_in;
         drv_rl_ff <= drv_rl_in;
         drv_rr_ff <= drv_rr_in;
         est_f_ff  <= est_f_in;
         est_s_ff  <= est_s_in;
         est_t_ff  <= est_t_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_fl_rpm = drv_fl_ff;
   assign rsp_drive_fr_rpm = drv_fr_ff;
   assign rsp_drive_rl_rpm = drv_rl_ff;
   assign rsp_drive_rr_rpm = drv_rr_ff;
   assign rsp_est_forward  = est_f_ff;
   assign rsp_est_sideways = est_s_ff;
   assign rsp_est_turn     = est_t_ff;

endmodule

// ===== bench/tb_wheeled_base_kinematics.sv =====
module tb_wheeled_base_kinematics;

   import wbk_pkg::*;

   // Opcodes of a request and the two register indexes the block does not decode.
   localparam logic                OpInverse = 1'b0;
   localparam logic                OpForward = 1'b1;
   localparam logic [CsrIdxW-1:0]  RegSpare6 = 3'd6;
   localparam logic [CsrIdxW-1:0]  RegSpare7 = 3'd7;

   localparam int ResetCycles  = 9;
   localparam int RandomItems  = 1330;
   localparam int IdlePct      = 12;
   localparam int DrainCycles  = 8;     // pipeline is three deep, leave some margin
   localparam int StallLimit   = 500;   // cycles without any transfer before giving up
   localparam int MaxReports   = 30;    // keep the log short when everything breaks

   typedef struct packed {
      logic               opcode;
      logic [FieldW-1:0]  cmd_forward;
      logic [FieldW-1:0]  cmd_sideways;
      logic [FieldW-1:0]  cmd_turn;
      logic [FieldW-1:0]  wheel_fl;
      logic [FieldW-1:0]  wheel_fr;
      logic [FieldW-1:0]  wheel_rl;
      logic [FieldW-1:0]  wheel_rr;
   } motion_request_type;

   typedef struct packed {
      logic [FieldW-1:0]  drive_fl;
      logic [FieldW-1:0]  drive_fr;
      logic [FieldW-1:0]  drive_rl;
      logic [FieldW-1:0]  drive_rr;
      logic [FieldW-1:0]  est_forward;
      logic [FieldW-1:0]  est_sideways;
      logic [FieldW-1:0]  est_turn;
   } kinematics_result_type;

   // Shadow of the block's registers, updated on every register transfer.
   typedef struct packed {
      logic [BaseW-1:0]     base_type;
      logic [MaxRpmW-1:0]   max_rpm;
      logic [InvCoefW-1:0]  rpm_per_speed;
      logic [InvCoefW-1:0]  rpm_per_turn;
      logic [CoefW-1:0]     speed_per_rpm;
      logic [CoefW-1:0]     turn_per_rpm;
   } base_setup_type;

   // A hand-written answer travels with each request; typed == 0 means "ask the predictor".
   typedef struct packed {
      logic                   typed;
      kinematics_result_type  want;
   } answer_type;

   // One line of the directed script: either a register transfer or a request.
   typedef struct packed {
      logic                   is_write;
      logic [CsrIdxW-1:0]     idx;
      logic [CsrDataW-1:0]    data;
      motion_request_type     rq;
      logic                   typed;
      kinematics_result_type  want;
   } script_row_type;

   localparam base_setup_type SetupAfterReset = '{
      base_type:     RstBaseType,
      max_rpm:       RstMaxRpm,
      rpm_per_speed: RstRpmPerSpeed,
      rpm_per_turn:  RstRpmPerTurn,
      speed_per_rpm: RstSpeedPerRpm,
      turn_per_rpm:  RstTurnPerRpm
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_opcode = OpInverse;
   logic signed [FieldW-1:0]   req_cmd_forward = '0;
   logic signed [FieldW-1:0]   req_cmd_sideways = '0;
   logic signed [FieldW-1:0]   req_cmd_turn = '0;
   logic signed [FieldW-1:0]   req_wheel_fl_rpm = '0;
   logic signed [FieldW-1:0]   req_wheel_fr_rpm = '0;
   logic signed [FieldW-1:0]   req_wheel_rl_rpm = '0;
   logic signed [FieldW-1:0]   req_wheel_rr_rpm = '0;
   logic                       rsp_valid;
   logic signed [FieldW-1:0]   rsp_drive_fl_rpm;
   logic signed [FieldW-1:0]   rsp_drive_fr_rpm;
   logic signed [FieldW-1:0]   rsp_drive_rl_rpm;
   logic signed [FieldW-1:0]   rsp_drive_rr_rpm;
   logic signed [FieldW-1:0]   rsp_est_forward;
   logic signed [FieldW-1:0]   rsp_est_sideways;
   logic signed [FieldW-1:0]   rsp_est_turn;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CsrIdxW-1:0]         csr_index = '0;
   logic [CsrDataW-1:0]        csr_data = '0;

   base_setup_type         setup = SetupAfterReset;
   kinematics_result_type  due_results[$];     // expected wheel/body results, oldest first
   answer_type             row_answers[$];     // hand-written answers for requests in flight
   script_row_type         script[$];
   motion_request_type     seen_request;
   kinematics_result_type  oldest_due;
   answer_type             answer;

   int idle_pct = IdlePct;
   int stall_count = 0;
   int mismatch_count = 0;
   int n_accepted = 0;
   int n_issued = 0;
   int n_results = 0;
   int n_writes = 0;
   int n_directed = 0;
   int n_settings = 1;

   always #4 clock = ~clock;

   wheeled_base_kinematics u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_cmd_forward  (req_cmd_forward),
      .req_cmd_sideways (req_cmd_sideways),
      .req_cmd_turn     (req_cmd_turn),
      .req_wheel_fl_rpm (req_wheel_fl_rpm),
      .req_wheel_fr_rpm (req_wheel_fr_rpm),
      .req_wheel_rl_rpm (req_wheel_rl_rpm),
      .req_wheel_rr_rpm (req_wheel_rr_rpm),
      .rsp_valid        (rsp_valid),
      .rsp_drive_fl_rpm (rsp_drive_fl_rpm),
      .rsp_drive_fr_rpm (rsp_drive_fr_rpm),
      .rsp_drive_rl_rpm (rsp_drive_rl_rpm),
      .rsp_drive_rr_rpm (rsp_drive_rr_rpm),
      .rsp_est_forward  (rsp_est_forward),
      .rsp_est_sideways (rsp_est_sideways),
      .rsp_est_turn     (rsp_est_turn),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ---------------------------------------------------------------- prediction

   // Divide by 2^n, rounding toward zero like the block does for both signs.
   function automatic longint shift_toward_zero(input longint v, input int unsigned n);
      if (v < 0) begin
         return -((-v) >>> n);
      end
      return v >>> n;
   endfunction

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      if (v < lo) begin
         return lo;
      end
      if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic kinematics_result_type predict_kinematics(input motion_request_type rq,
                                                                input base_setup_type su);
      kinematics_result_type res;
      longint f, s, t, x, y, r, lim, a, b, c, d, sx, sy, sw;
      int unsigned k;
      res = '0;
      if (rq.opcode == OpInverse) begin
         f = $signed(rq.cmd_forward);
         s = $signed(rq.cmd_sideways);
         t = $signed(rq.cmd_turn);
         // Car-like bases steer instead of turning in place; only mecanum slides sideways.
         if (su.base_type == BaseAck || su.base_type == BaseAck1) begin
            s = 0;
            t = 0;
         end else if (su.base_type != BaseMec) begin
            s = 0;
         end
         x = f * longint'(su.rpm_per_speed);
         y = s * longint'(su.rpm_per_speed);
         r = t * longint'(su.rpm_per_turn);
         lim = longint'(su.max_rpm);
         res.drive_fl = FieldW'(clamp_to(shift_toward_zero(x - y - r, 16), -lim, lim));
         res.drive_fr = FieldW'(clamp_to(shift_toward_zero(x + y + r, 16), -lim, lim));
         res.drive_rl = FieldW'(clamp_to(shift_toward_zero(x + y - r, 16), -lim, lim));
         res.drive_rr = FieldW'(clamp_to(shift_toward_zero(x - y + r, 16), -lim, lim));
      end else begin
         a = $signed(rq.wheel_fl);
         b = $signed(rq.wheel_fr);
         c = $signed(rq.wheel_rl);
         d = $signed(rq.wheel_rr);
         sx = a + b + c + d;
         sy = -a + b + c - d;
         sw = -a + b - c + d;
         // Average over the driven wheels: one, four, or two for everything else
         // (the undecoded base types fall back to two).
         if (su.base_type == BaseAck1) begin
            k = 0;
         end else if (su.base_type == BaseSkid || su.base_type == BaseMec) begin
            k = 2;
         end else begin
            k = 1;
         end
         res.est_forward = FieldW'(clamp_to(shift_toward_zero(sx * longint'(su.speed_per_rpm),
                                                              16 + k), -32768, 32767));
         if (su.base_type == BaseMec) begin
            res.est_sideways = FieldW'(clamp_to(shift_toward_zero(sy * longint'(su.speed_per_rpm),
                                                                  16 + k), -32768, 32767));
         end
         res.est_turn = FieldW'(clamp_to(shift_toward_zero(sw * longint'(su.turn_per_rpm),
                                                           16 + k), -32768, 32767));
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MaxReports) begin
         $display("MISMATCH @%0t result %0d: %s", $time, n_results, what);
      end
   endtask

   task automatic compare_field(input string name, input logic [FieldW-1:0] got,
                                input logic [FieldW-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, want %0d", name, $signed(got), $signed(want)));
      end
   endtask

   // Sample everything at the rising edge, before the block's own updates land:
   // record request and register transfers, and hold each result up against the
   // oldest outstanding expectation.
   always @(posedge clock) begin
      if (reset) begin
         setup = SetupAfterReset;
         stall_count = 0;
      end else begin
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               report_mismatch("result arrived with no request outstanding");
            end else begin
               oldest_due = due_results.pop_front();
               compare_field("drive_fl_rpm", rsp_drive_fl_rpm, oldest_due.drive_fl);
               compare_field("drive_fr_rpm", rsp_drive_fr_rpm, oldest_due.drive_fr);
               compare_field("drive_rl_rpm", rsp_drive_rl_rpm, oldest_due.drive_rl);
               compare_field("drive_rr_rpm", rsp_drive_rr_rpm, oldest_due.drive_rr);
               compare_field("est_forward", rsp_est_forward, oldest_due.est_forward);
               compare_field("est_sideways", rsp_est_sideways, oldest_due.est_sideways);
               compare_field("est_turn", rsp_est_turn, oldest_due.est_turn);
            end
            n_results++;
         end
         if (start && !busy) begin
            seen_request = '{req_opcode, req_cmd_forward, req_cmd_sideways, req_cmd_turn,
                             req_wheel_fl_rpm, req_wheel_fr_rpm, req_wheel_rl_rpm,
                             req_wheel_rr_rpm};
            answer = row_answers.pop_front();
            due_results.push_back(answer.typed ? answer.want
                                               : predict_kinematics(seen_request, setup));
            n_accepted++;
         end
         if (csr_valid && csr_ready) begin
            // Keep only the bits each register holds; spare indexes change nothing.
            case (csr_index)
               RegBaseType:    setup.base_type     = csr_data[BaseW-1:0];
               RegMaxRpm:      setup.max_rpm       = csr_data[MaxRpmW-1:0];
               RegRpmPerSpeed: setup.rpm_per_speed = csr_data[InvCoefW-1:0];
               RegRpmPerTurn:  setup.rpm_per_turn  = csr_data[InvCoefW-1:0];
               RegSpeedPerRpm: setup.speed_per_rpm = csr_data[CoefW-1:0];
               RegTurnPerRpm:  setup.turn_per_rpm  = csr_data[CoefW-1:0];
               default: ;
            endcase
            n_writes++;
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            stall_count = 0;
         end else begin
            stall_count++;
         end
      end
   end

   // Drop the run if traffic stops altogether.
   initial begin
      wait (stall_count >= StallLimit);
      $display("watchdog: %0d cycles without a transfer, %0d results still due",
               stall_count, due_results.size());
      $display("wheeled_base_kinematics verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   // Bias toward the rails and toward small values that stay inside the clamps.
   function automatic logic [FieldW-1:0] random_field();
      case ($urandom_range(19))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0001;
         5, 6, 7, 8, 9, 10, 11: return FieldW'($urandom_range(4000) - 2000);
         default: return FieldW'($urandom);
      endcase
   endfunction

   function automatic motion_request_type random_request();
      motion_request_type rq;
      rq.opcode       = 1'($urandom_range(1));
      rq.cmd_forward  = random_field();
      rq.cmd_sideways = random_field();
      rq.cmd_turn     = random_field();
      rq.wheel_fl     = random_field();
      rq.wheel_fr     = random_field();
      rq.wheel_rl     = random_field();
      rq.wheel_rr     = random_field();
      return rq;
   endfunction

   // Mostly plausible robot geometry, with zero, all-ones and raw random thrown in.
   function automatic logic [CsrDataW-1:0] pick_register_value(input logic [CsrIdxW-1:0] idx);
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2, 3: return CsrDataW'($urandom);
         default: begin
            case (idx)
               RegBaseType:    return CsrDataW'($urandom_range(4));
               RegMaxRpm:      return CsrDataW'($urandom_range(5000, 50));
               RegRpmPerSpeed: return CsrDataW'($urandom_range(80000, 1000));
               RegRpmPerTurn:  return CsrDataW'($urandom_range(30000, 200));
               RegSpeedPerRpm: return CsrDataW'($urandom_range(2000000, 50000));
               default:        return CsrDataW'($urandom_range(4000000, 100000));
            endcase
         end
      endcase
   endfunction

   task automatic drive_fields(input motion_request_type rq);
      req_opcode       <= rq.opcode;
      req_cmd_forward  <= rq.cmd_forward;
      req_cmd_sideways <= rq.cmd_sideways;
      req_cmd_turn     <= rq.cmd_turn;
      req_wheel_fl_rpm <= rq.wheel_fl;
      req_wheel_fr_rpm <= rq.wheel_fr;
      req_wheel_rl_rpm <= rq.wheel_rl;
      req_wheel_rr_rpm <= rq.wheel_rr;
   endtask

   // Offer one request; idle at random first, with junk on the fields to show
   // that nothing is taken while start is low. Returns at the transfer edge.
   task automatic drive_request(input motion_request_type rq, input logic typed,
                                input kinematics_result_type want);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         drive_fields(random_request());
         @(posedge clock);
      end
      row_answers.push_back(answer_type'{typed, want});
      start <= 1'b1;
      drive_fields(rq);
      do @(posedge clock); while (busy);
      n_issued++;
   endtask

   // Hold requests off until every request handed over has its result back.
   // The count of handed-over requests is kept by drive_request, so it never lags the edge.
   task automatic settle_pipeline();
      start <= 1'b0;
      while (n_results < n_issued) begin
         @(posedge clock);
      end
   endtask

   // Leave csr_valid high; the caller drops it once, so back-to-back transfers
   // never see it lowered and raised in the same step.
   task automatic write_register(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_random_setup();
      logic [CsrIdxW-1:0] idx;
      for (idx = RegBaseType; idx <= RegTurnPerRpm; idx++) begin
         write_register(idx, pick_register_value(idx));
      end
      if ($urandom_range(3) == 0) begin
         write_register($urandom_range(1) ? RegSpare6 : RegSpare7, CsrDataW'($urandom));
      end
      n_settings++;
   endtask

   // ---------------------------------------------------------------- directed script

   function automatic script_row_type reg_row(input logic [CsrIdxW-1:0] idx,
                                              input logic [CsrDataW-1:0] data);
      script_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.idx = idx;
      row.data = data;
      return row;
   endfunction

   function automatic script_row_type inv_row(input int f, input int s, input int t);
      script_row_type row;
      row = '0;
      row.rq.opcode = OpInverse;
      row.rq.cmd_forward = FieldW'(f);
      row.rq.cmd_sideways = FieldW'(s);
      row.rq.cmd_turn = FieldW'(t);
      return row;
   endfunction

   function automatic script_row_type fwd_row(input int fl, input int fr, input int rl,
                                              input int rr);
      script_row_type row;
      row = '0;
      row.rq.opcode = OpForward;
      row.rq.wheel_fl = FieldW'(fl);
      row.rq.wheel_fr = FieldW'(fr);
      row.rq.wheel_rl = FieldW'(rl);
      row.rq.wheel_rr = FieldW'(rr);
      return row;
   endfunction

   function automatic script_row_type with_drive(input script_row_type row, input int fl,
                                                 input int fr, input int rl, input int rr);
      row.typed = 1'b1;
      row.want = '0;
      row.want.drive_fl = FieldW'(fl);
      row.want.drive_fr = FieldW'(fr);
      row.want.drive_rl = FieldW'(rl);
      row.want.drive_rr = FieldW'(rr);
      return row;
   endfunction

   function automatic script_row_type with_est(input script_row_type row, input int fwd,
                                               input int side, input int turn);
      row.typed = 1'b1;
      row.want = '0;
      row.want.est_forward = FieldW'(fwd);
      row.want.est_sideways = FieldW'(side);
      row.want.est_turn = FieldW'(turn);
      return row;
   endfunction

   task automatic build_script();
      // Out of reset: mecanum, clamp at 330 RPM.
      script.push_back(with_drive(inv_row(0, 0, 0), 0, 0, 0, 0));
      script.push_back(with_drive(inv_row(32767, 0, 0), 330, 330, 330, 330));
      script.push_back(with_drive(inv_row(-32768, 0, 0), -330, -330, -330, -330));
      script.push_back(inv_row(0, 32767, 0));
      script.push_back(inv_row(0, 0, -32768));
      script.push_back(inv_row(32767, -32768, 32767));
      script.push_back(with_est(fwd_row(0, 0, 0, 0), 0, 0, 0));
      script.push_back(with_est(fwd_row(32767, 32767, 32767, 32767), 32767, 0, 0));
      script.push_back(with_est(fwd_row(-32768, -32768, -32768, -32768), -32768, 0, 0));
      script.push_back(fwd_row(-32768, 32767, 32767, -32768));
      script.push_back(fwd_row(-32768, 32767, -32768, 32767));
      // Spare indexes must leave every register alone.
      script.push_back(reg_row(RegSpare6, 24'hFFFFFF));
      script.push_back(reg_row(RegSpare7, 24'hFFFFFF));
      script.push_back(inv_row(1000, 500, -200));
      script.push_back(fwd_row(120, -7, 300, 45));
      // Widest clamp and largest inverse factors; upper data bits must be dropped.
      script.push_back(reg_row(RegMaxRpm, 24'hFF7FFF));
      script.push_back(reg_row(RegRpmPerSpeed, 24'hFFFFFF));
      script.push_back(reg_row(RegRpmPerTurn, 24'hFFFFFF));
      script.push_back(with_drive(inv_row(32767, 0, 0), 32767, 32767, 32767, 32767));
      script.push_back(with_drive(inv_row(0, 0, -32768), 32767, -32767, 32767, -32767));
      // Walk the base types, the undecoded one included.
      script.push_back(reg_row(RegBaseType, CsrDataW'(BaseDiff)));
      script.push_back(inv_row(1234, 32767, -777));
      script.push_back(fwd_row(900, -32768, 4, 32767));
      script.push_back(reg_row(RegBaseType, CsrDataW'(BaseAck)));
      script.push_back(inv_row(-32768, 32767, 32767));
      script.push_back(fwd_row(-32768, 32767, 17, -3));
      script.push_back(reg_row(RegBaseType, CsrDataW'(BaseAck1)));
      script.push_back(fwd_row(32767, -32768, 32767, -32768));
      script.push_back(inv_row(300, -300, 300));
      script.push_back(reg_row(RegBaseType, CsrDataW'(BaseSkid)));
      script.push_back(fwd_row(-500, 700, -32768, 32767));
      script.push_back(inv_row(-20, 32767, 32767));
      script.push_back(reg_row(RegBaseType, 24'hFFFFFF));
      script.push_back(inv_row(40, 32767, -32768));
      // Largest forward factors with the undecoded base: two wheels, no sideways.
      script.push_back(reg_row(RegSpeedPerRpm, 24'hFFFFFF));
      script.push_back(reg_row(RegTurnPerRpm, 24'hFFFFFF));
      script.push_back(with_est(fwd_row(32767, 32767, 32767, 32767), 32767, 0, 0));
      // A zero clamp silences every wheel; zero factors silence every estimate.
      script.push_back(reg_row(RegMaxRpm, 24'h000000));
      script.push_back(with_drive(inv_row(32767, -32768, 32767), 0, 0, 0, 0));
      script.push_back(reg_row(RegSpeedPerRpm, 24'h000000));
      script.push_back(reg_row(RegTurnPerRpm, 24'h000000));
      script.push_back(with_est(fwd_row(32767, -32768, -1, 1), 0, 0, 0));
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      int phase_len;
      int phase;
      int n_random;
      build_script();
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed part: register rows wait for an empty pipeline, request rows go
      // straight in with the usual random idling.
      foreach (script[i]) begin
         if (script[i].is_write) begin
            settle_pipeline();
            write_register(script[i].idx, script[i].data);
            n_settings++;
         end else begin
            csr_valid <= 1'b0;
            drive_request(script[i].rq, script[i].typed, script[i].want);
            n_directed++;
         end
      end

      // Random part: phases of random requests, each under a fresh register setup.
      // Phases three and four run without idling to keep the pipeline full.
      phase = 0;
      n_random = 0;
      while (n_random < RandomItems) begin
         settle_pipeline();
         load_random_setup();
         csr_valid <= 1'b0;
         idle_pct = (phase == 3 || phase == 4) ? 0 : IdlePct;
         phase_len = $urandom_range(120, 40);
         if (phase_len > RandomItems - n_random) begin
            phase_len = RandomItems - n_random;
         end
         repeat (phase_len) begin
            drive_request(random_request(), 1'b0, '0);
            n_random++;
         end
         phase++;
      end

      settle_pipeline();
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d requests (%0d directed, %0d random) under %0d register setups",
               n_accepted, n_directed, n_random, n_settings);
      $display("compared %0d results field by field; %0d register transfers; %0d mismatches",
               n_results, n_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("wheeled_base_kinematics verification clean");
      end else begin
         $display("wheeled_base_kinematics verification failed");
      end
      $finish;
   end

endmodule
